>>> sv/rbst_pkg.sv
// Package for the ray versus box slab test.
// Holds default widths and the box register index codes; no dependencies.
package rbst_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int CFG_IDX_WIDTH   = 3;

	// Box register indexes on the configuration channel
	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_MIN_X = 3'd0,
		REG_MIN_Y = 3'd1,
		REG_MIN_Z = 3'd2,
		REG_MAX_X = 3'd3,
		REG_MAX_Y = 3'd4,
		REG_MAX_Z = 3'd5
	} cfg_reg_t;

	// Cycles from start to result strobe for a given coordinate width:
	// one numerator stage, the divider (entry, one stage per bit, exit), two merge stages
	function automatic int result_latency(input int coord_width);
		return coord_width + 5;
	endfunction

endpackage

>>> sv/rbst_div.sv
// Pipelined signed fixed-point divider, one quotient bit per stage, saturating.
// Depends on nothing; used by rbst_lane.
module rbst_div #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic signed [W:0]   num,
	input  logic signed [W-1:0] den,
	output logic                out_valid,
	output logic signed [W-1:0] quo
);

	localparam int DW = 2 * W + 1;

	logic [W:0]    n_mag;
	logic [W-1:0]  m_mag;
	logic [DW-1:0] dfull;
	logic          sat_c;

	// Take magnitudes and spot an integer part too large for the format
	always_comb begin
		n_mag = num[W] ? (W+1)'(-num) : (W+1)'(num);
		m_mag = den[W-1] ? W'(-den) : W'(den);
		dfull = DW'(n_mag) << F;
		sat_c = DW'(n_mag) >= (DW'(m_mag) << (W - F));
	end

	logic          vld_s [0:W+1];
	logic          neg_s [0:W+1];
	logic          sat_s [0:W+1];
	logic [W-1:0]  den_s [0:W+1];
	logic [W-1:0]  rem_s [0:W+1];
	logic [W-1:0]  dlo_s [0:W+1];
	logic [W-1:0]  quo_s [0:W+1];

	// Entry stage: start remainder from the dividend's high part
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		neg_s[0] <= num[W] ^ den[W-1];
		sat_s[0] <= sat_c;
		den_s[0] <= m_mag;
		rem_s[0] <= dfull[2*W-1:W];
		dlo_s[0] <= dfull[W-1:0];
		quo_s[0] <= '0;
	end

	// One restoring step per stage
	for (genvar k = 0; k < W; k++) begin : g_step
		logic [W:0] trial;
		logic       ge;

		always_comb begin
			trial = {rem_s[k], dlo_s[k][W-1]};
			ge    = trial >= {1'b0, den_s[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			neg_s[k+1] <= neg_s[k];
			sat_s[k+1] <= sat_s[k];
			den_s[k+1] <= den_s[k];
			rem_s[k+1] <= ge ? W'(trial - {1'b0, den_s[k]}) : W'(trial);
			dlo_s[k+1] <= {dlo_s[k][W-2:0], 1'b0};
			quo_s[k+1] <= {quo_s[k][W-2:0], ge};
		end
	end

	logic [W-1:0] limit;
	logic [W-1:0] qclip;

	// Clip to the format's range and restore the sign
	always_comb begin
		limit = neg_s[W] ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - W'(1));
		qclip = (sat_s[W] || (quo_s[W] > limit)) ? limit : quo_s[W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[W+1] <= 1'b0;
		end else begin
			vld_s[W+1] <= vld_s[W];
		end
	end

	always_ff @(posedge clk) begin
		quo_s[W+1] <= neg_s[W] ? W'(-qclip) : qclip;
		neg_s[W+1] <= neg_s[W];
		sat_s[W+1] <= sat_s[W];
		den_s[W+1] <= den_s[W];
		rem_s[W+1] <= rem_s[W];
		dlo_s[W+1] <= dlo_s[W];
	end

	assign out_valid = vld_s[W+1];
	assign quo       = quo_s[W+1];

endmodule

>>> sv/rbst_lane.sv
// One axis lane: slab numerators, entry/exit ordering, two dividers.
// Depends on rbst_div.
module rbst_lane #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic signed [W-1:0] lo_b,
	input  logic signed [W-1:0] hi_b,
	input  logic signed [W-1:0] org,
	input  logic signed [W-1:0] dir,
	output logic                out_valid,
	output logic                miss,
	output logic signed [W-1:0] t_in,
	output logic signed [W-1:0] t_out
);

	localparam int DLAT = W + 2;

	logic signed [W:0] num_lo, num_hi;

	// Distances from origin to both bounds
	always_comb begin
		num_lo = (W+1)'(lo_b) - (W+1)'(org);
		num_hi = (W+1)'(hi_b) - (W+1)'(org);
	end

	logic                vld_s1;
	logic signed [W:0]   nin_s1, nout_s1;
	logic signed [W-1:0] dir_s1;
	logic                zero_s1, inside_s1;

	// Order the bounds by the direction's sign
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		nin_s1    <= dir[W-1] ? num_hi : num_lo;
		nout_s1   <= dir[W-1] ? num_lo : num_hi;
		dir_s1    <= dir;
		zero_s1   <= (dir == '0);
		inside_s1 <= (org >= lo_b) && (org <= hi_b);
	end

	logic signed [W-1:0] q_in, q_out;
	logic                div_valid;
	logic                div_out_valid;

	rbst_div #(.W(W), .F(F)) u_div_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.num       (nin_s1),
		.den       (dir_s1),
		.out_valid (div_valid),
		.quo       (q_in)
	);

	rbst_div #(.W(W), .F(F)) u_div_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.num       (nout_s1),
		.den       (dir_s1),
		.out_valid (div_out_valid),
		.quo       (q_out)
	);

	// Carry the zero-direction flags alongside the dividers
	logic zero_d   [0:DLAT-1];
	logic inside_d [0:DLAT-1];

	always_ff @(posedge clk) begin
		zero_d[0]   <= zero_s1;
		inside_d[0] <= inside_s1;
		for (int i = 1; i < DLAT; i++) begin
			zero_d[i]   <= zero_d[i-1];
			inside_d[i] <= inside_d[i-1];
		end
	end

	// Zero direction spans all distances, or misses outside the slab
	always_comb begin
		out_valid = div_valid && div_out_valid;
		miss      = zero_d[DLAT-1] && !inside_d[DLAT-1];
		t_in      = zero_d[DLAT-1] ? {1'b1, {(W-1){1'b0}}} : q_in;
		t_out     = zero_d[DLAT-1] ? {1'b0, {(W-1){1'b1}}} : q_out;
	end

endmodule

>>> sv/rbst_merge.sv
// Merge stage: intersects the x, y and z intervals and decides the hit.
// No dependencies; used by the top level.
module rbst_merge #(
	parameter int W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                miss_x,
	input  logic                miss_y,
	input  logic                miss_z,
	input  logic signed [W-1:0] x_in,
	input  logic signed [W-1:0] x_out,
	input  logic signed [W-1:0] y_in,
	input  logic signed [W-1:0] y_out,
	input  logic signed [W-1:0] z_in,
	input  logic signed [W-1:0] z_out,
	output logic                out_valid,
	output logic                hit
);

	logic                vld_s1, ok_s1, zmiss_s1;
	logic signed [W-1:0] in_s1, out_s1, zin_s1, zout_s1;

	// Intersect x with y
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		ok_s1    <= !miss_x && !miss_y && !(x_in > y_out || y_in > x_out);
		in_s1    <= (y_in > x_in) ? y_in : x_in;
		out_s1   <= (y_out < x_out) ? y_out : x_out;
		zmiss_s1 <= miss_z;
		zin_s1   <= z_in;
		zout_s1  <= z_out;
	end

	logic signed [W-1:0] out_fin;
	logic                hit_c;

	// Intersect with z and test the exit ahead of the origin
	always_comb begin
		out_fin = (zout_s1 < out_s1) ? zout_s1 : out_s1;
		hit_c   = ok_s1 && !zmiss_s1 && !(in_s1 > zout_s1 || zin_s1 > out_s1)
			&& (out_fin > 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			hit       <= 1'b0;
		end else begin
			out_valid <= vld_s1;
			hit       <= vld_s1 && hit_c;
		end
	end

endmodule

>>> sv/ray_box_slab_test.sv
// Top level of the ray versus box slab test: box registers, three axis lanes, merge.
// Depends on rbst_pkg, rbst_lane, rbst_div and rbst_merge.
//
// A ray is taken on every cycle that start is high (busy is always low) and its hit
// flag appears with a one-cycle result_valid strobe after one numerator stage, the
// bit-per-stage divider pipeline (COORD_WIDTH + 2 stages) and two interval merge
// stages. Results come in order and cannot be held off. Box bounds are written
// over the cfg channel (cfg_ready is always high) and
// must only change while no ray is in flight.
module ray_box_slab_test #(
	parameter int COORD_WIDTH = rbst_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = rbst_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [COORD_WIDTH-1:0]       origin_x,
	input  logic signed [COORD_WIDTH-1:0]       origin_y,
	input  logic signed [COORD_WIDTH-1:0]       origin_z,
	input  logic signed [COORD_WIDTH-1:0]       dir_x,
	input  logic signed [COORD_WIDTH-1:0]       dir_y,
	input  logic signed [COORD_WIDTH-1:0]       dir_z,
	output logic                                result_valid,
	output logic                                hit,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rbst_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
	input  logic [COORD_WIDTH-1:0]              cfg_data
);

	localparam int W = COORD_WIDTH;

	logic signed [W-1:0] min_x_q, min_y_q, min_z_q, max_x_q, max_y_q, max_z_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Write box registers; ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q <= '0;
			min_y_q <= '0;
			min_z_q <= '0;
			max_x_q <= '0;
			max_y_q <= '0;
			max_z_q <= '0;
		end else if (cfg_valid) begin
			unique case (rbst_pkg::cfg_reg_t'(cfg_index))
				rbst_pkg::REG_MIN_X: min_x_q <= cfg_data;
				rbst_pkg::REG_MIN_Y: min_y_q <= cfg_data;
				rbst_pkg::REG_MIN_Z: min_z_q <= cfg_data;
				rbst_pkg::REG_MAX_X: max_x_q <= cfg_data;
				rbst_pkg::REG_MAX_Y: max_y_q <= cfg_data;
				rbst_pkg::REG_MAX_Z: max_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic                vld_x, vld_y, vld_z;
	logic                miss_x, miss_y, miss_z;
	logic signed [W-1:0] x_in, x_out, y_in, y_out, z_in, z_out;

	rbst_lane #(.W(W), .F(FRAC_BITS)) u_lane_x (
		.clk(clk), .arst_n(arst_n), .in_valid(start),
		.lo_b(min_x_q), .hi_b(max_x_q), .org(origin_x), .dir(dir_x),
		.out_valid(vld_x), .miss(miss_x), .t_in(x_in), .t_out(x_out)
	);

	rbst_lane #(.W(W), .F(FRAC_BITS)) u_lane_y (
		.clk(clk), .arst_n(arst_n), .in_valid(start),
		.lo_b(min_y_q), .hi_b(max_y_q), .org(origin_y), .dir(dir_y),
		.out_valid(vld_y), .miss(miss_y), .t_in(y_in), .t_out(y_out)
	);

	rbst_lane #(.W(W), .F(FRAC_BITS)) u_lane_z (
		.clk(clk), .arst_n(arst_n), .in_valid(start),
		.lo_b(min_z_q), .hi_b(max_z_q), .org(origin_z), .dir(dir_z),
		.out_valid(vld_z), .miss(miss_z), .t_in(z_in), .t_out(z_out)
	);

	rbst_merge #(.W(W)) u_merge (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_x && vld_y && vld_z),
		.miss_x(miss_x), .miss_y(miss_y), .miss_z(miss_z),
		.x_in(x_in), .x_out(x_out), .y_in(y_in), .y_out(y_out),
		.z_in(z_in), .z_out(z_out),
		.out_valid(result_valid), .hit(hit)
	);

endmodule

>>> sv/rbst_checker.sv
// Port-level checker for ray_box_slab_test, attached by bind.
// Depends on rbst_pkg for the result latency.
module rbst_checker #(
	parameter int LAT = rbst_pkg::result_latency(rbst_pkg::COORD_WIDTH_DEF)
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic result_valid,
	input logic hit,
	input logic cfg_ready
);

	// Never refuse a ray
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// Every result traces back to an earlier ray taken on start
	a_result_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start, LAT))
		else $error("result without item");

	// Hit only shows with its strobe
	a_hit_qualified: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !hit)
		else $error("hit outside strobe");

	// Configuration is always taken
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("cfg_ready dropped");

endmodule

bind ray_box_slab_test rbst_checker #(
	.LAT(rbst_pkg::result_latency(COORD_WIDTH))
) u_rbst_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.result_valid(result_valid), .hit(hit), .cfg_ready(cfg_ready)
);
